>>> design/pcl_pkg.sv
// Shared types, constants and unit control codes for the mesh cell locator.
package pcl_pkg;

  localparam int unsigned WidthW    = 22;
  localparam int unsigned CountW    = 11;
  localparam int unsigned SeedW     = 10;
  localparam int unsigned PosW      = 32;
  localparam int unsigned ProdW     = CountW + WidthW;
  localparam int unsigned AccW      = ProdW + 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned MaxCellsDefault = 1024;

  localparam logic [WidthW-1:0]  CellWidthReset = 22'd2097152;
  localparam logic [CountW-1:0]  CellCountReset = 11'd1024;

  localparam logic [CfgIdxW-1:0] RegCellWidth = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCellCount = 1'd1;

  typedef struct packed {
    logic [SeedW-1:0]       seed_cell;
    logic signed [PosW-1:0] position;
  } pcl_in_t;

  typedef struct packed {
    logic [SeedW-1:0] cell_index;
    logic             inside_domain;
  } pcl_out_t;

  typedef enum logic [1:0] {
    UOP_HOLD,
    UOP_MUL,
    UOP_ADD,
    UOP_SUB
  } pcl_uop_e;

  typedef struct packed {
    pcl_uop_e          op;
    logic [CountW-1:0] idx;
  } pcl_unit_ctrl_t;

  typedef struct packed {
    logic pos_lt;
    logic pos_gt;
  } pcl_unit_stat_t;

endpackage

>>> design/pic_particle_cell_locator.sv
// Top level of the 1-D mesh cell locator: sequencer, registers and channels.
//
// Input beats carry a seed cell and a signed position; each accepted beat
// yields exactly one output beat with the cell index and a domain flag.
// in_stall_o is high while an item is being worked on; the block takes one
// item at a time. Output beats wait in an output register while out_stall_i
// is high, and the sequencer holds its result until that register frees up.
// Steps: the domain length and then the seed bound each use the shared
// multiplier, then the walk steps one cell per cycle through the single
// add/compare unit. A search that finds no cell runs to the end of the
// mesh first. The next item can be taken in the cycle after the result
// is loaded. The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i)
// writes the cell width and cell count; the user must see that it is
// written only while the block is idle, as the block does not enforce it.
// Reset returns the cell width to 2097152 and the count to 1024, empties
// the output register and leaves the block ready for a new beat.
module pic_particle_cell_locator #(
  parameter int unsigned MAX_CELLS = pcl_pkg::MaxCellsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pcl_pkg::WidthW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pcl_pkg::pcl_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pcl_pkg::pcl_out_t             out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOMAIN,
    ST_SEED,
    ST_HIGH,
    ST_UP,
    ST_DOWN,
    ST_FINISH
  } state_e;

  state_e                         state_q;
  logic [pcl_pkg::WidthW-1:0]     width_q;
  logic [pcl_pkg::CountW-1:0]     count_q;
  logic signed [pcl_pkg::PosW-1:0] pos_q;
  logic [pcl_pkg::CountW-1:0]     cnt_q;
  logic [pcl_pkg::CountW-1:0]     seed_q;
  logic [pcl_pkg::CountW-1:0]     idx_q;
  logic [pcl_pkg::CountW-1:0]     res_q;
  logic                           inside_q;
  logic                           out_valid_q;
  pcl_pkg::pcl_out_t              out_data_q;

  logic [pcl_pkg::CountW-1:0]     cnt_eff;
  logic [pcl_pkg::CountW-1:0]     seed_ext;
  logic [pcl_pkg::CountW-1:0]     seed_clamped;
  logic [pcl_pkg::CountW:0]       idx_inc;
  logic                           pos_positive;
  logic                           out_free;
  pcl_pkg::pcl_unit_ctrl_t        unit_ctrl;
  pcl_pkg::pcl_unit_stat_t        unit_stat;

  // A count of zero acts as one cell; a count above the limit is clipped.
  always_comb begin
    if (count_q == '0) begin
      cnt_eff = pcl_pkg::CountW'(1);
    end else if (32'(count_q) > 32'(MAX_CELLS)) begin
      cnt_eff = pcl_pkg::CountW'(MAX_CELLS);
    end else begin
      cnt_eff = count_q;
    end
  end

  assign seed_ext     = pcl_pkg::CountW'(in_data_i.seed_cell);
  assign seed_clamped = (seed_ext >= cnt_eff) ? cnt_eff - 1'b1 : seed_ext;
  assign idx_inc      = {1'b0, idx_q} + 1'b1;
  assign pos_positive = !pos_q[pcl_pkg::PosW-1] && (pos_q != '0);
  assign out_free     = !out_valid_q || !out_stall_i;

  always_comb begin
    unit_ctrl.op  = pcl_pkg::UOP_HOLD;
    unit_ctrl.idx = seed_q;
    unique case (state_q)
      ST_DOMAIN: begin
        unit_ctrl.op  = pcl_pkg::UOP_MUL;
        unit_ctrl.idx = cnt_q;
      end
      ST_SEED: begin
        unit_ctrl.op = pcl_pkg::UOP_MUL;
      end
      ST_HIGH, ST_UP: begin
        unit_ctrl.op = pcl_pkg::UOP_ADD;
      end
      ST_DOWN: begin
        unit_ctrl.op = pcl_pkg::UOP_SUB;
      end
      default: begin
        unit_ctrl.op = pcl_pkg::UOP_HOLD;
      end
    endcase
  end

  pcl_bound_unit u_bound (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (unit_ctrl),
    .cell_width_i (width_q),
    .position_i   (pos_q),
    .status_o     (unit_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= pcl_pkg::CellWidthReset;
      count_q     <= pcl_pkg::CellCountReset;
      pos_q       <= '0;
      cnt_q       <= '0;
      seed_q      <= '0;
      idx_q       <= '0;
      res_q       <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pcl_pkg::RegCellWidth: width_q <= cfg_wdata_i;
          pcl_pkg::RegCellCount: count_q <= cfg_wdata_i[pcl_pkg::CountW-1:0];
          default: ;
        endcase
      end

      // In ST_FINISH the load below owns the valid flag.
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            pos_q   <= in_data_i.position;
            cnt_q   <= cnt_eff;
            seed_q  <= seed_clamped;
            idx_q   <= seed_clamped;
            res_q   <= seed_clamped;
            state_q <= ST_DOMAIN;
          end
        end
        ST_DOMAIN: begin
          inside_q <= pos_positive && unit_stat.pos_lt;
          state_q  <= ST_SEED;
        end
        ST_SEED: begin
          // Below the seed cell's lower bound: walk down, otherwise test the top.
          state_q <= unit_stat.pos_lt ? ST_DOWN : ST_HIGH;
        end
        ST_HIGH: begin
          state_q <= unit_stat.pos_gt ? ST_UP : ST_FINISH;
        end
        ST_UP: begin
          if (idx_inc >= {1'b0, cnt_q}) begin
            state_q <= ST_FINISH;
          end else begin
            idx_q <= idx_inc[pcl_pkg::CountW-1:0];
            if (!unit_stat.pos_gt) begin
              res_q   <= idx_inc[pcl_pkg::CountW-1:0];
              state_q <= ST_FINISH;
            end
          end
        end
        ST_DOWN: begin
          if (idx_q == '0) begin
            state_q <= ST_FINISH;
          end else begin
            idx_q <= idx_q - 1'b1;
            if (!unit_stat.pos_lt) begin
              res_q   <= idx_q - 1'b1;
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q              <= 1'b1;
            out_data_q.cell_index    <= res_q[pcl_pkg::SeedW-1:0];
            out_data_q.inside_domain <= inside_q;
            state_q                  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/pcl_bound_unit.sv
// Shared bound unit: multiplier, add/subtract accumulator and position compare.
module pcl_bound_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcl_pkg::pcl_unit_ctrl_t             ctrl_i,
  input  logic [pcl_pkg::WidthW-1:0]          cell_width_i,
  input  logic signed [pcl_pkg::PosW-1:0]     position_i,
  output pcl_pkg::pcl_unit_stat_t             status_o
);

  logic [pcl_pkg::ProdW-1:0]       prod;
  logic signed [pcl_pkg::AccW-1:0] width_ext;
  logic signed [pcl_pkg::AccW-1:0] pos_ext;
  logic signed [pcl_pkg::AccW-1:0] acc_d;
  logic signed [pcl_pkg::AccW-1:0] acc_q;

  assign prod      = pcl_pkg::ProdW'(ctrl_i.idx) * pcl_pkg::ProdW'(cell_width_i);
  assign width_ext = $signed({{(pcl_pkg::AccW - pcl_pkg::WidthW){1'b0}}, cell_width_i});
  assign pos_ext   = $signed({{(pcl_pkg::AccW - pcl_pkg::PosW){position_i[pcl_pkg::PosW-1]}},
                              position_i});

  always_comb begin
    unique case (ctrl_i.op)
      pcl_pkg::UOP_MUL: acc_d = $signed({2'b00, prod});
      pcl_pkg::UOP_ADD: acc_d = acc_q + width_ext;
      pcl_pkg::UOP_SUB: acc_d = acc_q - width_ext;
      default:          acc_d = acc_q;
    endcase
  end

  // The compare looks at the new bound, so one cell is stepped per cycle.
  assign status_o.pos_lt = pos_ext < acc_d;
  assign status_o.pos_gt = pos_ext > acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

>>> tb/tb_pic_particle_cell_locator.sv
// Self-checking testbench for the 1-D mesh cell locator: directed probes, then random traffic.
module tb_pic_particle_cell_locator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCells    = pcl_pkg::MaxCellsDefault;
  localparam int          NumProbes   = 23;
  localparam int          NumPhases   = 8;
  localparam int          PhaseItems  = 200;
  localparam int          SettleCycles = 8;
  localparam int          HoldCycles  = 300;
  localparam int          QuietLimit  = 10000;

  typedef struct {
    pcl_pkg::pcl_in_t  item;
    pcl_pkg::pcl_out_t result;
  } located_t;

  typedef struct {
    logic [pcl_pkg::WidthW-1:0] width_word;
    logic [pcl_pkg::WidthW-1:0] count_word;
    logic [pcl_pkg::SeedW-1:0]  seed;
    logic [pcl_pkg::PosW-1:0]   pos;
    bit                         typed;
    logic [pcl_pkg::SeedW-1:0]  exp_cell;
    logic                       exp_inside;
  } probe_row_t;

  logic                         clk_i;
  logic                         rst_ni    = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [pcl_pkg::CfgIdxW-1:0]  cfg_idx   = pcl_pkg::RegCellWidth;
  logic [pcl_pkg::WidthW-1:0]   cfg_wdata = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall_o;
  pcl_pkg::pcl_in_t             in_data   = '0;
  logic                         out_valid_o;
  logic                         out_stall = 1'b0;
  pcl_pkg::pcl_out_t            out_data_o;

  // Shadow copies of the two registers, as the block should hold them.
  logic [pcl_pkg::WidthW-1:0]   width_q = pcl_pkg::CellWidthReset;
  logic [pcl_pkg::CountW-1:0]   count_q = pcl_pkg::CellCountReset;

  located_t            pending_cells[$];
  int                  mismatches    = 0;
  int                  results_seen  = 0;
  int                  settings_used = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_reqs     = 0;
  int                  quiet_cycles  = 0;

  // Positions on boundaries, domain ends, clamped seeds and degenerate meshes.
  probe_row_t probes [0:NumProbes-1] = '{
    '{22'd2097152, 22'd1024, 10'd0,    32'h0000_0000, 1'b1, 10'd0,    1'b0},
    '{22'd2097152, 22'd1024, 10'd0,    32'h7FFF_FFFF, 1'b1, 10'd1023, 1'b1},
    '{22'd2097152, 22'd1024, 10'd1023, 32'h8000_0000, 1'b1, 10'd1023, 1'b0},
    '{22'd2097152, 22'd1024, 10'd512,  32'h4000_0000, 1'b1, 10'd512,  1'b1},
    '{22'd2097152, 22'd1024, 10'd5,    32'd10485760,  1'b1, 10'd5,    1'b1},
    '{22'd2097152, 22'd1024, 10'd10,   32'd10485760,  1'b0, 10'd0,    1'b0},
    '{22'd2097152, 22'd1024, 10'd0,    32'd10485760,  1'b0, 10'd0,    1'b0},
    '{22'd100,     22'd10,   10'd1023, 32'd950,       1'b1, 10'd9,    1'b1},
    '{22'd100,     22'd10,   10'd1023, 32'd1001,      1'b1, 10'd9,    1'b0},
    '{22'd100,     22'd10,   10'd9,    32'd150,       1'b0, 10'd0,    1'b0},
    '{22'd100,     22'd10,   10'd3,    32'd1000,      1'b0, 10'd0,    1'b0},
    '{22'd100,     22'h3FF800, 10'd1023, 32'd50,      1'b1, 10'd0,    1'b1},
    '{22'd100,     22'h3FF800, 10'd0,  32'd100,       1'b1, 10'd0,    1'b0},
    '{22'd1,       22'd2047, 10'd1023, 32'd1024,      1'b1, 10'd1023, 1'b0},
    '{22'd1,       22'd2047, 10'd0,    32'd1023,      1'b0, 10'd0,    1'b0},
    '{22'd0,       22'd16,   10'd3,    32'd0,         1'b1, 10'd3,    1'b0},
    '{22'd0,       22'd16,   10'd1023, 32'd7,         1'b1, 10'd15,   1'b0},
    '{22'd0,       22'd16,   10'd1023, 32'hFFFF_FFF9, 1'b1, 10'd15,   1'b0},
    '{22'h3FFFFF,  22'd1024, 10'd0,    32'h7FFF_FFFF, 1'b0, 10'd0,    1'b0},
    '{22'h3FFFFF,  22'd1024, 10'd0,    32'h8000_0000, 1'b1, 10'd0,    1'b0},
    '{22'd1,       22'd1,    10'd0,    32'd1,         1'b1, 10'd0,    1'b0},
    '{22'd1,       22'd1,    10'd0,    32'd2,         1'b1, 10'd0,    1'b0},
    '{22'd1,       22'd1,    10'd0,    32'hFFFF_FFFF, 1'b1, 10'd0,    1'b0}
  };

  pic_particle_cell_locator #(
    .MAX_CELLS(MaxCells)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint effective_count(input logic [pcl_pkg::CountW-1:0] cnt);
    longint c;
    c = cnt;
    if (c < 1) c = 1;
    if (c > MaxCells) c = MaxCells;
    return c;
  endfunction

  // Walk the mesh from the clamped seed toward the position, first closed cell wins.
  function automatic pcl_pkg::pcl_out_t locate_cell(input logic [pcl_pkg::WidthW-1:0] w_reg,
                                                    input logic [pcl_pkg::CountW-1:0] c_reg,
                                                    input pcl_pkg::pcl_in_t item);
    pcl_pkg::pcl_out_t res;
    longint            cnt, w, seed, pos, found;
    cnt = effective_count(c_reg);
    w = w_reg;
    seed = item.seed_cell;
    if (seed >= cnt) seed = cnt - 1;
    pos = longint'($signed(item.position));
    found = seed;
    if (pos < seed * w) begin
      for (longint i = seed - 1; i >= 0; i--) begin
        if (pos >= i * w && pos <= (i + 1) * w) begin
          found = i;
          break;
        end
      end
    end else if (pos > (seed + 1) * w) begin
      for (longint i = seed + 1; i < cnt; i++) begin
        if (pos >= i * w && pos <= (i + 1) * w) begin
          found = i;
          break;
        end
      end
    end
    res.cell_index = found[pcl_pkg::SeedW-1:0];
    res.inside_domain = (pos > 0 && pos < cnt * w);
    return res;
  endfunction

  // Mostly particles near their previous cell, plus edges, clamped seeds and noise.
  function automatic pcl_pkg::pcl_in_t random_probe();
    pcl_pkg::pcl_in_t item;
    longint           w, cnt, dom, s, d, pos;
    int               kind;
    w = width_q;
    cnt = effective_count(count_q);
    dom = cnt * w;
    kind = $urandom_range(0, 99);
    s = $urandom_range(0, 32'(cnt - 1));
    d = longint'($urandom_range(0, 4)) - 2;
    pos = (s + d) * w + longint'($urandom_range(0, 32'(w)));
    if (kind >= 75 && kind < 85) begin
      case ($urandom_range(0, 6))
        0: pos = 0;
        1: pos = -1;
        2: pos = 1;
        3: pos = dom;
        4: pos = dom - 1;
        5: pos = dom + 1;
        default: pos = longint'($urandom_range(0, 32'(cnt))) * w;
      endcase
    end else if (kind >= 85 && kind < 92) begin
      if (cnt < MaxCells) s = $urandom_range(32'(cnt), MaxCells - 1);
      else s = $urandom_range(0, MaxCells - 1);
      pos = (cnt - 1 + d) * w + longint'($urandom_range(0, 32'(w)));
    end else if (kind >= 92) begin
      s = $urandom_range(0, 1023);
      pos = longint'($urandom());
    end
    item.seed_cell = s[pcl_pkg::SeedW-1:0];
    item.position = pos[pcl_pkg::PosW-1:0];
    return item;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic push_item(input pcl_pkg::pcl_in_t item, input pcl_pkg::pcl_out_t result);
    located_t entry;
    entry.item = item;
    entry.result = result;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_cells.push_back(entry);
    @(negedge clk_i);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [pcl_pkg::CfgIdxW-1:0] idx,
                           input logic [pcl_pkg::WidthW-1:0] data);
    cfg_idx <= idx;
    cfg_wdata <= data;
    cfg_we <= 1'b1;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    if (idx == pcl_pkg::RegCellWidth) width_q = data;
    else count_q = data[pcl_pkg::CountW-1:0];
  endtask

  // Receiver: random stalls, or one long hold-off for each request.
  initial begin
    int held;
    int holds_done;
    held = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done < hold_reqs) begin
        out_stall <= 1'b1;
        held++;
        if (held == HoldCycles) begin
          holds_done++;
          held = 0;
        end
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    located_t head;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_cells.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected, cell %0d",
                                out_data_o.cell_index));
      end else begin
        head = pending_cells.pop_front();
        results_seen++;
        if (out_data_o.cell_index !== head.result.cell_index)
          flag_mismatch($sformatf("seed %0d pos %0d: cell_index %0d, expected %0d",
                                  head.item.seed_cell, $signed(head.item.position),
                                  out_data_o.cell_index, head.result.cell_index));
        if (out_data_o.inside_domain !== head.result.inside_domain)
          flag_mismatch($sformatf("seed %0d pos %0d: inside_domain %0b, expected %0b",
                                  head.item.seed_cell, $signed(head.item.position),
                                  out_data_o.inside_domain, head.result.inside_domain));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Watchdog: %0d cycles without a beat, %0d results outstanding",
                 quiet_cycles + 1, pending_cells.size());
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    pcl_pkg::pcl_in_t           item;
    pcl_pkg::pcl_out_t          result;
    logic [pcl_pkg::WidthW-1:0] w_word;
    logic [pcl_pkg::WidthW-1:0] c_word;
    int                         random_items;
    random_items = 0;
    send_idle_pct = 34;
    recv_idle_pct = 59;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumProbes; r++) begin
      if (probes[r].width_word != width_q ||
          probes[r].count_word[pcl_pkg::CountW-1:0] != count_q) begin
        drain_block();
        if (probes[r].width_word != width_q)
          write_reg(pcl_pkg::RegCellWidth, probes[r].width_word);
        if (probes[r].count_word[pcl_pkg::CountW-1:0] != count_q)
          write_reg(pcl_pkg::RegCellCount, probes[r].count_word);
        settings_used++;
      end
      item.seed_cell = probes[r].seed;
      item.position = probes[r].pos;
      if (probes[r].typed) begin
        result.cell_index = probes[r].exp_cell;
        result.inside_domain = probes[r].exp_inside;
      end else begin
        result = locate_cell(width_q, count_q, item);
      end
      push_item(item, result);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin w_word = pcl_pkg::CellWidthReset; c_word = 22'(pcl_pkg::CellCountReset); end
        1: begin w_word = 22'd1; c_word = 22'd1024; end
        2: begin w_word = 22'h3FFFFF; c_word = 22'd1024; end
        3: begin w_word = 22'd0; c_word = 22'($urandom_range(1, 64)); end
        4: begin w_word = 22'($urandom_range(1, 5000)); c_word = {11'($urandom()), 11'd0}; end
        5: begin w_word = 22'($urandom_range(1, 100000)); c_word = {11'($urandom()), 11'd2047}; end
        6: begin w_word = 22'($urandom_range(1, 4096)); c_word = 22'($urandom_range(1, 32)); end
        default: begin
          w_word = 22'($urandom_range(1, 22'h3FFFFF));
          c_word = 22'($urandom_range(1, 1024));
        end
      endcase
      // Results must all be out before the mesh changes under the block.
      drain_block();
      write_reg(pcl_pkg::RegCellWidth, w_word);
      write_reg(pcl_pkg::RegCellCount, c_word);
      settings_used++;
      if (ph == 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 34;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs++;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        item = random_probe();
        push_item(item, locate_cell(width_q, count_q, item));
        random_items++;
      end
    end

    drain_block();
    repeat (40) @(posedge clk_i);
    if (pending_cells.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", pending_cells.size()));
    $display("Run covered %0d directed and %0d random items across %0d mesh settings,",
             NumProbes, random_items, settings_used);
    $display("with %0d result beats checked and %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
